// File: rtl/core/gfmv_pkg.sv
// Shared types, constants and GF(256) arithmetic for the GF(256) matrix-vector product block.
`default_nettype none

package gfmv_pkg;

  // Storage limits
  localparam int MAX_ROWS    = 2048;
  localparam int MAX_COLUMNS = 256;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int ROW_CNT_W   = 12;
  localparam int COL_CNT_W   = 9;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;

  // Register reset values
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = ROW_CNT_W'(44);
  localparam logic [COL_CNT_W-1:0] COL_COUNT_RST = COL_CNT_W'(44);

  // Low byte of the reduction polynomial x^8+x^4+x^3+x+1
  localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1B;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_t;

  // Clamped limits, stored as last index
  typedef struct packed {
    row_t rows_m1;
    col_t cols_m1;
  } limits_t;

  // Position of the next item in the stream
  typedef struct packed {
    row_t row;
    logic first_col;
    logic last_col;
    logic last_row;
  } pos_t;

  // Shift-and-add multiply, reducing by the polynomial on each doubling
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t x;
    byte_t r;
    x = a;
    r = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) r = r ^ x;
      x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LOW : byte_t'(0));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gfmv_intf.sv
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface gfmv_in_if;
  import gfmv_pkg::*;
  logic  valid;
  logic  ready;
  byte_t matrix_byte;
  byte_t vector_coef;
  modport source (output valid, output matrix_byte, output vector_coef, input ready);
  modport sink   (input valid, input matrix_byte, input vector_coef, output ready);
endinterface

interface gfmv_out_if;
  import gfmv_pkg::*;
  logic  valid;
  logic  ready;
  byte_t product_byte;
  row_t  row_number;
  logic  last_row;
  modport source (output valid, output product_byte, output row_number, output last_row,
                  input ready);
  modport sink   (input valid, input product_byte, input row_number, input last_row,
                  output ready);
endinterface

interface gfmv_cfg_if;
  import gfmv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gfmv_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none

module gfmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/gfmv_cfg_regs.sv
// Configuration registers and their clamped last-index limits.
`default_nettype none

module gfmv_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  gfmv_cfg_if.sink          cfg_ch,
  output gfmv_pkg::limits_t limits
);
  import gfmv_pkg::*;

  logic [ROW_CNT_W-1:0] row_count_r, row_count_nxt;
  logic [COL_CNT_W-1:0] col_count_r, col_count_nxt;

  assign cfg_ch.ready = 1'b1;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ROW_COUNT:    row_count_nxt = cfg_ch.data[ROW_CNT_W-1:0];
        REG_COLUMN_COUNT: col_count_nxt = cfg_ch.data[COL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // Clamp to 1..MAX and convert to last index
  always_comb begin
    if (row_count_r == '0)
      limits.rows_m1 = '0;
    else if (row_count_r > ROW_CNT_W'(MAX_ROWS))
      limits.rows_m1 = row_t'(MAX_ROWS - 1);
    else
      limits.rows_m1 = row_t'(row_count_r - ROW_CNT_W'(1));

    if (col_count_r == '0)
      limits.cols_m1 = '0;
    else if (col_count_r > COL_CNT_W'(MAX_COLUMNS))
      limits.cols_m1 = col_t'(MAX_COLUMNS - 1);
    else
      limits.cols_m1 = col_t'(col_count_r - COL_CNT_W'(1));
  end

endmodule

`default_nettype wire

// File: rtl/core/gfmv_sequencer.sv
// Row and column position counters for the column-major stream.
`default_nettype none

module gfmv_sequencer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire gfmv_pkg::limits_t limits,
  input  wire logic         accept,
  output gfmv_pkg::pos_t    pos
);
  import gfmv_pkg::*;

  row_t row_r, row_nxt;
  col_t col_r, col_nxt;

  // A position at or past the last index counts as last
  assign pos.row       = row_r;
  assign pos.first_col = (col_r == '0);
  assign pos.last_col  = (col_r >= limits.cols_m1);
  assign pos.last_row  = (row_r >= limits.rows_m1);

  // Advance on each accepted transaction
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (pos.last_row) begin
        row_nxt = '0;
        col_nxt = pos.last_col ? col_t'(0) : col_r + col_t'(1);
      end else begin
        row_nxt = row_r + row_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gfmv_acc_stage.sv
// Input register, GF multiply, accumulator read-modify-write and result register.
`default_nettype none

module gfmv_acc_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  gfmv_in_if.sink        in_ch,
  gfmv_out_if.source     out_ch,
  input  wire gfmv_pkg::pos_t pos,
  output logic           accept
);
  import gfmv_pkg::*;

  // Work stage registers
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_a_r, s1_b_r;
  pos_t  s1_pos_r;
  logic  s1_fwd_hit_r;
  byte_t s1_fwd_data_r;

  // Result register
  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r;
  row_t  out_row_r;
  logic  out_last_r;

  byte_t rd_data;
  byte_t acc_base;
  byte_t acc;
  logic  s1_adv;

  // Stage moves on unless it emits into a full, stalled result register
  assign s1_adv = s1_valid_r &&
                  (!s1_pos_r.last_col || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // Accumulator store; read issued at accept, written when the stage moves on
  gfmv_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROWS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r.row),
    .wdata (acc),
    .re    (accept),
    .raddr (pos.row),
    .rdata (rd_data)
  );

  // Forwarded value covers a write to the same row in the cycle of the read
  assign acc_base = s1_fwd_hit_r ? s1_fwd_data_r : rd_data;
  assign acc      = s1_pos_r.first_col ? gf_mul(s1_a_r, s1_b_r)
                                       : acc_base ^ gf_mul(s1_a_r, s1_b_r);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)
      s1_valid_nxt = 1'b1;
    else if (s1_adv)
      s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a_r        <= in_ch.matrix_byte;
      s1_b_r        <= in_ch.vector_coef;
      s1_pos_r      <= pos;
      s1_fwd_hit_r  <= s1_adv && (s1_pos_r.row == pos.row);
      s1_fwd_data_r <= acc;
    end
  end

  // Result register load and drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_pos_r.last_col)
      out_valid_nxt = 1'b1;
    else if (out_ch.ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos_r.last_col) begin
      out_byte_r <= acc;
      out_row_r  <= s1_pos_r.row;
      out_last_r <= s1_pos_r.last_row;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.product_byte = out_byte_r;
  assign out_ch.row_number   = out_row_r;
  assign out_ch.last_row     = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/gf256_matrix_vector_product.sv
// Top level of the GF(256) matrix-vector product block.
//
// Computes c = A*b over GF(2^8), polynomial 0x11B. The matrix streams in
// column-major order on in_ch, one element per transaction together with the
// vector coefficient of its column. Each product is XORed into the row's
// accumulator; the first column overwrites it. Transactions of the last column
// each return one result on out_ch: the finished byte, its row number and a
// flag on the final row. Other transactions return nothing.
// cfg_ch writes row_count (index 0) and column_count (index 1); it is always
// ready and must be used only while the block is idle.
// Throughput: one transaction per cycle unless out_ch stalls, set by the read-
// modify-write of the accumulator RAM (registered read issued at accept, write
// when the work stage moves on, with same-row forwarding). A result passes from
// the work stage registers into the output register, valid there until taken.
// Reset clears the positions and loads both registers with 44; accumulators
// are not cleared and need no clearing pass. When out_ch stalls, a result
// waits in the output register; one more item can sit in the work stage, and
// in_ch drops ready only if that item also has a result to deliver.
`default_nettype none

module gf256_matrix_vector_product (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gfmv_cfg_if.sink    cfg_ch,
  gfmv_in_if.sink     in_ch,
  gfmv_out_if.source  out_ch
);
  import gfmv_pkg::*;

  limits_t limits;
  pos_t    pos;
  logic    accept;

  gfmv_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .limits (limits)
  );

  gfmv_sequencer u_sequencer (
    .clk    (clk),
    .rst_n  (rst_n),
    .limits (limits),
    .accept (accept),
    .pos    (pos)
  );

  gfmv_acc_stage u_acc_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .pos    (pos),
    .accept (accept)
  );

endmodule

`default_nettype wire
